// ===== hw/rtl/t12_pkg.sv =====
package t12_pkg;

  localparam int MemWords = 4096;
  localparam int MemAw    = $clog2(MemWords);

  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_DEP   = 2'd1,
    OP_LDPC  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_HALT = 2'd1,
    ST_IOT  = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    IR_AND = 3'd0,
    IR_TAD = 3'd1,
    IR_ISZ = 3'd2,
    IR_DCA = 3'd3,
    IR_JMS = 3'd4,
    IR_JMP = 3'd5,
    IR_IOT = 3'd6,
    IR_OPR = 3'd7
  } ir_e;

  typedef struct packed {
    logic [12:0] ac;
    logic [11:0] mq;
    logic        skip;
    logic        halt;
  } opr_res_t;

  function automatic logic [12:0] rot_r(input logic [12:0] v);
    return {v[0], v[12:1]};
  endfunction

  function automatic logic [12:0] rot_l(input logic [12:0] v);
    return {v[11:0], v[12]};
  endfunction

  // Operate instruction, groups 1..3, in standard event order
  function automatic opr_res_t opr_exec(input logic [11:0] w, input logic [12:0] ac_in,
                                        input logic [11:0] mq_in, input logic [11:0] sr);
    opr_res_t   r;
    logic [12:0] ac;
    logic        sk;
    ac = ac_in;
    sk = 1'b0;
    r.mq = mq_in;
    r.halt = 1'b0;
    if (!w[8]) begin
      if (w[7]) ac = ac & 13'h1000;
      if (w[6]) ac = ac & 13'h0fff;
      if (w[5]) ac = ac ^ 13'h0fff;
      if (w[4]) ac = ac ^ 13'h1000;
      if (w[0]) ac = ac + 13'd1;
      if (w[3]) begin
        ac = rot_r(ac);
        if (w[1]) ac = rot_r(ac);
      end
      if (w[2]) begin
        ac = rot_l(ac);
        if (w[1]) ac = rot_l(ac);
      end
      if (!w[3] && !w[2] && w[1]) ac = {ac[12], ac[5:0], ac[11:6]};
    end else if (!w[0]) begin
      if (w[6] && ac[11]) sk = 1'b1;
      if (w[5] && ac[11:0] == 12'd0) sk = 1'b1;
      if (w[4] && ac[12]) sk = 1'b1;
      if (w[3]) sk = !sk;
      if (w[7]) ac = ac & 13'h1000;
      if (w[2]) ac = ac | {1'b0, sr};
      r.halt = w[1];
    end else begin
      if (w[7]) ac = ac & 13'h1000;
      if (w[6] && w[4]) begin
        r.mq = ac[11:0];
        ac = {ac[12], mq_in};
      end else begin
        if (w[6]) ac = ac | {1'b0, mq_in};
        if (w[4]) begin
          r.mq = ac[11:0];
          ac = ac & 13'h1000;
        end
      end
    end
    r.ac = ac;
    r.skip = sk;
    return r;
  endfunction

endpackage

// ===== hw/rtl/t12_ram.sv =====
module t12_ram #(
  parameter int Aw = 12,
  parameter int Dw = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [Dw-1:0] wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [Dw-1:0] rdata_o
);

  logic [Dw-1:0] mem [2**Aw];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/twelve_bit_minicomputer_core.sv =====
// Twelve-bit minicomputer core with a 4K-word main memory.
// Input channel (in_valid_i/in_ready_o) takes one word: op_i selects execute
// one instruction at the PC, deposit data_i at address_i, or load the PC
// from address_i. Every word gives exactly one result word on the output
// channel (out_valid_o/out_ready_i): status, PC, AC, link, MQ, IOT word.
// The config channel (cfg_valid_i/cfg_ready_o) loads the switch register,
// always ready; write it only while the core is idle.
// Deposit, load PC and unused ops finish in the cycle after acceptance.
// Execute steps through fetch, indirect read, auto-increment write and
// operand access as the instruction needs; operate, IOT and direct
// JMP/JMS/DCA end at fetch. The memory has one read and one write port.
// The result sits in an output register; a new word is taken while the
// previous result is being taken, and held off while it stalls.
// After reset all 4096 memory words are swept to zero, during which no
// input word is accepted. AC, link, PC, MQ and switches reset to zero.
module twelve_bit_minicomputer_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [11:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            op_i,
  input  logic [11:0]           address_i,
  input  logic [11:0]           data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [11:0]           next_pc_o,
  output logic [11:0]           accumulator_o,
  output logic                  link_o,
  output logic [11:0]           multiplier_quotient_o,
  output logic [11:0]           iot_word_o
);
  import t12_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FETCH = 6'b000100,
    S_IND   = 6'b001000,
    S_ADDR  = 6'b010000,
    S_OPER  = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [MemAw-1:0] clr_q, clr_d;
  logic [11:0] pc_q, pc_d;
  logic [12:0] ac_q, ac_d;
  logic [11:0] mq_q, mq_d;
  logic [11:0] sr_q;
  logic [11:0] w_q, w_d;
  logic [11:0] ea_q, ea_d;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [11:0] iot_q;

  logic        we, re;
  logic [11:0] waddr, wdata, raddr;
  logic [11:0] rdata;

  logic        done;
  status_e     status;
  logic [11:0] iot;
  logic [11:0] pcn;
  logic [11:0] ea0;
  logic [11:0] inc;
  logic        accept;
  opr_res_t    opr;

  t12_ram #(.Aw(MemAw), .Dw(12)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[MemAw-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr[MemAw-1:0]),
    .rdata_o (rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;

  assign pcn = (state_q == S_FETCH) ? pc_q + 12'd1 : pc_q;
  assign ea0 = {(rdata[7] ? pc_q[11:7] : 5'd0), rdata[6:0]};
  assign inc = rdata + 12'd1;
  assign opr = opr_exec(rdata, ac_q, mq_q, sr_q);

  always_comb begin
    logic [11:0] ea;
    logic        go_ea;
    ea      = ea_q;
    go_ea   = 1'b0;
    state_d = state_q;
    clr_d   = clr_q;
    pc_d    = pc_q;
    ac_d    = ac_q;
    mq_d    = mq_q;
    w_d     = w_q;
    ea_d    = ea_q;
    we      = 1'b0;
    waddr   = ea_q;
    wdata   = 12'd0;
    re      = 1'b0;
    raddr   = ea_q;
    done    = 1'b0;
    status  = ST_RUN;
    iot     = 12'd0;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = 12'(clr_q);
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (op_e'(op_i))
            OP_EXEC: begin
              re      = 1'b1;
              raddr   = pc_q;
              state_d = S_FETCH;
            end
            OP_DEP: begin
              we    = 1'b1;
              waddr = address_i;
              wdata = data_i;
              done  = 1'b1;
            end
            OP_LDPC: begin
              pc_d = address_i;
              done = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
      end
      S_FETCH: begin
        w_d  = rdata;
        pc_d = pcn;
        case (ir_e'(rdata[11:9]))
          IR_IOT: begin
            done    = 1'b1;
            status  = ST_IOT;
            iot     = rdata;
            state_d = S_IDLE;
          end
          IR_OPR: begin
            ac_d    = opr.ac;
            mq_d    = opr.mq;
            pc_d    = pcn + {11'd0, opr.skip};
            done    = 1'b1;
            status  = opr.halt ? ST_HALT : ST_RUN;
            state_d = S_IDLE;
          end
          default: begin
            if (rdata[8]) begin
              re      = 1'b1;
              raddr   = ea0;
              ea_d    = ea0;
              state_d = S_IND;
            end else begin
              ea    = ea0;
              go_ea = 1'b1;
            end
          end
        endcase
      end
      S_IND: begin
        if (ea_q[11:3] == 9'o001) begin
          // auto-index: write back, then re-issue from the new pointer
          we      = 1'b1;
          waddr   = ea_q;
          wdata   = inc;
          ea_d    = inc;
          state_d = S_ADDR;
        end else begin
          ea    = rdata;
          go_ea = 1'b1;
        end
      end
      S_ADDR: begin
        ea    = ea_q;
        go_ea = 1'b1;
      end
      S_OPER: begin
        case (ir_e'(w_q[11:9]))
          IR_AND: ac_d = {ac_q[12], ac_q[11:0] & rdata};
          IR_TAD: ac_d = ac_q + {1'b0, rdata};
          default: begin
            we    = 1'b1;
            waddr = ea_q;
            wdata = inc;
            if (inc == 12'd0) pc_d = pc_q + 12'd1;
          end
        endcase
        done    = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (go_ea) begin
      ea_d = ea;
      case (ir_e'(w_d[11:9]))
        IR_DCA: begin
          we      = 1'b1;
          waddr   = ea;
          wdata   = ac_q[11:0];
          ac_d    = ac_q & 13'h1000;
          done    = 1'b1;
          state_d = S_IDLE;
        end
        IR_JMS: begin
          we      = 1'b1;
          waddr   = ea;
          wdata   = pcn;
          pc_d    = ea + 12'd1;
          done    = 1'b1;
          state_d = S_IDLE;
        end
        IR_JMP: begin
          pc_d    = ea;
          done    = 1'b1;
          state_d = S_IDLE;
        end
        default: begin
          re      = 1'b1;
          raddr   = ea;
          state_d = S_OPER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pc_q        <= '0;
      ac_q        <= '0;
      mq_q        <= '0;
      sr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pc_q    <= pc_d;
      ac_q    <= ac_d;
      mq_q    <= mq_d;
      if (cfg_valid_i) sr_q <= cfg_data_i;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= w_d;
    ea_q <= ea_d;
    if (done) begin
      status_q <= status;
      iot_q    <= iot;
    end
  end

  // PC/AC/MQ are only touched by the word in flight, so the live
  // registers double as the result word.
  assign out_valid_o           = out_valid_q;
  assign status_o              = status_q;
  assign next_pc_o             = pc_q;
  assign accumulator_o         = ac_q[11:0];
  assign link_o                = ac_q[12];
  assign multiplier_quotient_o = mq_q;
  assign iot_word_o            = iot_q;

endmodule
